[hw/rtl/bglb_pkg.sv]
// Package for the button gesture LED blinker.
// Holds the gesture and LED mode codes, field widths and register reset values.
// No dependencies.
package bglb_pkg;

	localparam int unsigned DebounceW = 8;
	localparam int unsigned CountW    = 16;
	localparam int unsigned CfgDataW  = 16;
	localparam int unsigned CfgIdxW   = 2;

	typedef enum logic [1:0] {
		G_IDLE    = 2'd0,
		G_PRESSED = 2'd1,
		G_HELD    = 2'd2
	} gesture_t;

	typedef enum logic [1:0] {
		M_OFF  = 2'd0,
		M_SLOW = 2'd1,
		M_FAST = 2'd2
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		R_DEBOUNCE = 2'd0,
		R_HOLD     = 2'd1,
		R_SLOW     = 2'd2,
		R_FAST     = 2'd3
	} reg_idx_t;

	localparam logic [DebounceW-1:0] DebounceReset = 8'd20;
	localparam logic [CountW-1:0]    HoldReset     = 16'd1000;
	localparam logic [CountW-1:0]    SlowReset     = 16'd500;
	localparam logic [CountW-1:0]    FastReset     = 16'd100;

	localparam logic [DebounceW-1:0] LockoutMax = '1;
	localparam logic [CountW-1:0]    CountMax   = '1;

endpackage

[hw/rtl/button_gesture_led_blinker.sv]
// Top level of the button gesture LED blinker.
// Debounce, short/long press detection and LED blink generation in one pass.
// Depends on bglb_pkg.
//
// Usage:
// Each input word is one millisecond tick carrying the sampled button level
// (button_down). Each accepted word produces exactly one result word with the
// LED level, the gesture state, the LED mode and the chosen speed, all as they
// stand after that tick.
// The result is registered: a word is shown on the output channel in the cycle
// after it is accepted. Throughput is one word per cycle while the receiver
// keeps up; the limit is the single state update that each tick performs.
// in_ready is high whenever the output register is empty or being emptied in
// the same cycle, so a stalled receiver stops the input only while a result
// is still waiting; no word is dropped or repeated.
// Reset clears all state (LED high, idle, off, slow) and loads the register
// defaults: debounce 20, hold 1000, slow half-period 500, fast 100.
// Registers are written through cfg_we/cfg_index/cfg_wdata at any edge; they
// should only change while no tick is in flight.
module button_gesture_led_blinker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bglb_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bglb_pkg::CfgDataW-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          button_down,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          led_level,
	output logic [1:0]                    gesture_state,
	output logic [1:0]                    led_mode,
	output logic                          speed_fast
);

	logic [bglb_pkg::DebounceW-1:0] debounce_q;
	logic [bglb_pkg::CountW-1:0]    hold_ticks_q;
	logic [bglb_pkg::CountW-1:0]    slow_half_q;
	logic [bglb_pkg::CountW-1:0]    fast_half_q;

	logic                           last_level_q;
	logic [bglb_pkg::DebounceW-1:0] lockout_q;
	bglb_pkg::gesture_t             gesture_q;
	logic [bglb_pkg::CountW-1:0]    hold_cnt_q;
	bglb_pkg::mode_t                mode_q;
	logic                           speed_q;
	logic [bglb_pkg::CountW-1:0]    blink_cnt_q;
	logic                           led_q;
	logic                           out_valid_q;

	logic                           in_fire;
	logic [bglb_pkg::DebounceW-1:0] lockout_inc;
	logic                           edge_ok;
	logic [bglb_pkg::DebounceW-1:0] lockout_d;
	bglb_pkg::gesture_t             gesture_d;
	logic [bglb_pkg::CountW-1:0]    hold_inc;
	logic [bglb_pkg::CountW-1:0]    hold_cnt_d;
	bglb_pkg::mode_t                mode_d;
	logic                           speed_d;
	logic [bglb_pkg::CountW-1:0]    blink_inc;
	logic [bglb_pkg::CountW-1:0]    blink_cnt_d;
	logic [bglb_pkg::CountW-1:0]    half_sel;
	logic                           led_d;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= bglb_pkg::DebounceReset;
			hold_ticks_q <= bglb_pkg::HoldReset;
			slow_half_q  <= bglb_pkg::SlowReset;
			fast_half_q  <= bglb_pkg::FastReset;
		end else if (cfg_we) begin
			unique case (bglb_pkg::reg_idx_t'(cfg_index))
				bglb_pkg::R_DEBOUNCE: debounce_q   <= cfg_wdata[bglb_pkg::DebounceW-1:0];
				bglb_pkg::R_HOLD:     hold_ticks_q <= cfg_wdata;
				bglb_pkg::R_SLOW:     slow_half_q  <= cfg_wdata;
				bglb_pkg::R_FAST:     fast_half_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// One tick of the gesture and blink state.
	always_comb begin
		lockout_inc = (lockout_q == bglb_pkg::LockoutMax) ? lockout_q
			: lockout_q + bglb_pkg::DebounceW'(1);
		edge_ok     = (button_down != last_level_q) && (lockout_inc >= debounce_q);
		lockout_d   = edge_ok ? '0 : lockout_inc;

		gesture_d  = gesture_q;
		hold_cnt_d = hold_cnt_q;
		mode_d     = mode_q;
		speed_d    = speed_q;
		hold_inc   = (hold_cnt_q == bglb_pkg::CountMax) ? hold_cnt_q
			: hold_cnt_q + bglb_pkg::CountW'(1);

		if (edge_ok) begin
			if (gesture_q == bglb_pkg::G_IDLE) begin
				gesture_d  = bglb_pkg::G_PRESSED;
				hold_cnt_d = '0;
			end else begin
				// A short press toggles between off and the current speed.
				if (gesture_q == bglb_pkg::G_PRESSED) begin
					mode_d = (mode_q == bglb_pkg::M_OFF)
						? (speed_q ? bglb_pkg::M_FAST : bglb_pkg::M_SLOW)
						: bglb_pkg::M_OFF;
				end
				gesture_d = bglb_pkg::G_IDLE;
			end
		end else if (gesture_q != bglb_pkg::G_IDLE) begin
			hold_cnt_d = hold_inc;
			if (hold_inc >= hold_ticks_q) begin
				if (button_down) begin
					gesture_d  = bglb_pkg::G_HELD;
					speed_d    = !speed_q;
					mode_d     = speed_q ? bglb_pkg::M_SLOW : bglb_pkg::M_FAST;
					hold_cnt_d = '0;
				end else begin
					// The release edge was lost to the debounce window.
					gesture_d = bglb_pkg::G_IDLE;
				end
			end
		end

		half_sel    = (mode_d == bglb_pkg::M_FAST) ? fast_half_q : slow_half_q;
		blink_inc   = (blink_cnt_q == bglb_pkg::CountMax) ? blink_cnt_q
			: blink_cnt_q + bglb_pkg::CountW'(1);
		led_d       = led_q;
		blink_cnt_d = blink_inc;
		if (mode_d == bglb_pkg::M_OFF) begin
			led_d       = 1'b1;
			blink_cnt_d = '0;
		end else if (blink_inc >= half_sel) begin
			led_d       = !led_q;
			blink_cnt_d = '0;
		end
	end

	// The state registers double as the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b0;
			lockout_q    <= '0;
			gesture_q    <= bglb_pkg::G_IDLE;
			hold_cnt_q   <= '0;
			mode_q       <= bglb_pkg::M_OFF;
			speed_q      <= 1'b0;
			blink_cnt_q  <= '0;
			led_q        <= 1'b1;
		end else if (in_fire) begin
			last_level_q <= button_down;
			lockout_q    <= lockout_d;
			gesture_q    <= gesture_d;
			hold_cnt_q   <= hold_cnt_d;
			mode_q       <= mode_d;
			speed_q      <= speed_d;
			blink_cnt_q  <= blink_cnt_d;
			led_q        <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign led_level     = led_q;
	assign gesture_state = gesture_q;
	assign led_mode      = mode_q;
	assign speed_fast    = speed_q;

	a_off_led_high: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == bglb_pkg::M_OFF) |-> led_q)
		else $error("LED not high while mode is off");

	a_mode_matches_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != bglb_pkg::M_OFF) |->
			((mode_q == bglb_pkg::M_SLOW && !speed_q) ||
			 (mode_q == bglb_pkg::M_FAST && speed_q)))
		else $error("Blink mode disagrees with chosen speed");

	a_edge_clears_lockout: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && edge_ok) |=> (lockout_q == '0))
		else $error("Accepted edge did not restart the lockout");

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("Accepted tick produced no result word");

	a_speed_only_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (speed_d != speed_q)) |-> (gesture_d == bglb_pkg::G_HELD))
		else $error("Speed changed outside a hold");

endmodule

[test/tb_button_gesture_led_blinker.sv]
// Self-checking testbench for button_gesture_led_blinker: tick words in, status words out,
// with random stalls on both channels checked against a cycle-free model of the blinker.
// Depends on bglb_pkg and the button_gesture_led_blinker RTL.
`timescale 1ns / 100ps

module tb_button_gesture_led_blinker;

	localparam int StallLimit = 1000;
	localparam int SqueezeCycles = 60;

	typedef struct packed {
		logic                 led;
		bglb_pkg::gesture_t   gest;
		bglb_pkg::mode_t      md;
		logic                 fast;
	} blink_word_t;

	typedef struct packed {
		logic [bglb_pkg::DebounceW-1:0] deb;
		logic [bglb_pkg::CountW-1:0]    hold;
		logic [bglb_pkg::CountW-1:0]    slow;
		logic [bglb_pkg::CountW-1:0]    fast;
	} reg_set_t;

	typedef struct packed {
		bit          load;
		logic        btn;
		bit          typed;
		blink_word_t word;
	} script_row_t;

	localparam blink_word_t IdleWord = '{1'b1, bglb_pkg::G_IDLE, bglb_pkg::M_OFF, 1'b0};

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [bglb_pkg::CfgIdxW-1:0]  cfg_index;
	logic [bglb_pkg::CfgDataW-1:0] cfg_wdata;
	logic                          in_valid;
	logic                          in_ready;
	logic                          button_down;
	logic                          out_valid;
	logic                          out_ready;
	logic                          led_level;
	logic [1:0]                    gesture_state;
	logic [1:0]                    led_mode;
	logic                          speed_fast;

	// Blinker state as the checker sees it, with the register copies.
	logic                           p_last = 1'b0;
	logic [bglb_pkg::DebounceW-1:0] p_lockout = '0;
	bglb_pkg::gesture_t             p_gest = bglb_pkg::G_IDLE;
	logic [bglb_pkg::CountW-1:0]    p_hold = '0;
	bglb_pkg::mode_t                p_mode = bglb_pkg::M_OFF;
	logic                           p_speed = 1'b0;
	logic [bglb_pkg::CountW-1:0]    p_blink = '0;
	logic                           p_led = 1'b1;
	logic [bglb_pkg::DebounceW-1:0] c_debounce = bglb_pkg::DebounceReset;
	logic [bglb_pkg::CountW-1:0]    c_hold = bglb_pkg::HoldReset;
	logic [bglb_pkg::CountW-1:0]    c_slow = bglb_pkg::SlowReset;
	logic [bglb_pkg::CountW-1:0]    c_fast = bglb_pkg::FastReset;

	blink_word_t pending_words[$];
	int          mismatches = 0;
	int          ticks_sent = 0;
	bit          calm = 1'b0;
	bit          squeeze_req = 1'b0;
	bit          typed_on = 1'b0;
	blink_word_t typed_word = IdleWord;

	reg_set_t dir_sets[3] = '{
		'{8'd0, 16'd0, 16'd0, 16'd0},
		'{8'd3, 16'd4, 16'd1, 16'd2},
		'{8'd255, 16'd65535, 16'd65535, 16'd65535}
	};

	script_row_t script[25] = '{
		'{1'b0, 1'b0, 1'b1, IdleWord},
		'{1'b0, 1'b1, 1'b1, IdleWord},
		'{1'b0, 1'b0, 1'b1, IdleWord},
		'{1'b1, 1'b0, 1'b0, IdleWord},
		'{1'b0, 1'b1, 1'b1, '{1'b1, bglb_pkg::G_PRESSED, bglb_pkg::M_OFF, 1'b0}},
		'{1'b0, 1'b1, 1'b0, IdleWord},
		'{1'b0, 1'b1, 1'b0, IdleWord},
		'{1'b0, 1'b0, 1'b0, IdleWord},
		'{1'b0, 1'b1, 1'b0, IdleWord},
		'{1'b0, 1'b0, 1'b0, IdleWord},
		'{1'b0, 1'b1, 1'b0, IdleWord},
		'{1'b0, 1'b0, 1'b0, IdleWord},
		'{1'b1, 1'b0, 1'b0, IdleWord},
		'{1'b0, 1'b0, 1'b0, IdleWord},
		'{1'b0, 1'b0, 1'b0, IdleWord},
		'{1'b0, 1'b0, 1'b0, IdleWord},
		'{1'b0, 1'b1, 1'b0, IdleWord},
		'{1'b0, 1'b0, 1'b0, IdleWord},
		'{1'b0, 1'b0, 1'b0, IdleWord},
		'{1'b0, 1'b0, 1'b0, IdleWord},
		'{1'b0, 1'b0, 1'b0, IdleWord},
		'{1'b0, 1'b0, 1'b0, IdleWord},
		'{1'b1, 1'b0, 1'b0, IdleWord},
		'{1'b0, 1'b1, 1'b0, IdleWord},
		'{1'b0, 1'b0, 1'b0, IdleWord}
	};

	button_gesture_led_blinker u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.button_down  (button_down),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.led_level    (led_level),
		.gesture_state(gesture_state),
		.led_mode     (led_mode),
		.speed_fast   (speed_fast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// One millisecond tick of the blinker: debounce, gesture, then LED.
	task automatic advance_blinker(input logic lvl, output blink_word_t w);
		logic                        take;
		logic [bglb_pkg::CountW-1:0] half;
		if (p_lockout != bglb_pkg::LockoutMax)
			p_lockout = p_lockout + 1'b1;
		take = (lvl != p_last) && (p_lockout >= c_debounce);
		if (take)
			p_lockout = '0;
		p_last = lvl;

		if (take) begin
			if (p_gest == bglb_pkg::G_IDLE) begin
				p_gest = bglb_pkg::G_PRESSED;
				p_hold = '0;
			end else begin
				if (p_gest == bglb_pkg::G_PRESSED)
					p_mode = (p_mode == bglb_pkg::M_OFF)
						? (p_speed ? bglb_pkg::M_FAST : bglb_pkg::M_SLOW)
						: bglb_pkg::M_OFF;
				p_gest = bglb_pkg::G_IDLE;
			end
		end else if (p_gest == bglb_pkg::G_PRESSED || p_gest == bglb_pkg::G_HELD) begin
			if (p_hold != bglb_pkg::CountMax)
				p_hold = p_hold + 1'b1;
			if (p_hold >= c_hold) begin
				if (lvl) begin
					p_gest = bglb_pkg::G_HELD;
					p_speed = ~p_speed;
					p_mode = p_speed ? bglb_pkg::M_FAST : bglb_pkg::M_SLOW;
					p_hold = '0;
				end else begin
					p_gest = bglb_pkg::G_IDLE;
				end
			end
		end

		if (p_mode == bglb_pkg::M_OFF) begin
			p_led = 1'b1;
			p_blink = '0;
		end else begin
			half = (p_mode == bglb_pkg::M_FAST) ? c_fast : c_slow;
			if (p_blink != bglb_pkg::CountMax)
				p_blink = p_blink + 1'b1;
			if (p_blink >= half) begin
				p_led = ~p_led;
				p_blink = '0;
			end
		end
		w = '{p_led, p_gest, p_mode, p_speed};
	endtask

	task automatic report_field(input string what, input logic [1:0] want, input logic [1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		blink_word_t want;
		blink_word_t next_word;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_words.size() == 0) begin
					$display("%0t ns: status word with none expected (led %0d gesture %0d mode %0d fast %0d)",
						$time, led_level, gesture_state, led_mode, speed_fast);
					mismatches++;
				end else begin
					want = pending_words.pop_front();
					report_field("led_level", want.led, led_level);
					report_field("gesture_state", want.gest, gesture_state);
					report_field("led_mode", want.md, led_mode);
					report_field("speed_fast", want.fast, speed_fast);
				end
			end
			if (in_valid && in_ready) begin
				advance_blinker(button_down, next_word);
				pending_words.push_back(typed_on ? typed_word : next_word);
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		while (stall < StallLimit) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				stall = 0;
			else
				stall++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				out_ready <= 1'b0;
				repeat (SqueezeCycles) @(negedge clk);
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 22);
		end
	end

	function automatic bit sender_gap();
		return !calm && ($urandom_range(0, 99) < 22);
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_tick(input logic lvl, input bit typed, input blink_word_t w);
		while (sender_gap()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		typed_on = typed;
		typed_word = w;
		in_valid <= 1'b1;
		button_down <= lvl;
		do
			@(posedge clk);
		while (!in_ready);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic program_regs(input reg_set_t s);
		logic [bglb_pkg::CfgDataW-1:0] vals[4];
		bglb_pkg::reg_idx_t            idx;
		// The debounce register is narrower than the bus; the upper byte must be dropped.
		vals = '{{8'($urandom), s.deb}, s.hold, s.slow, s.fast};
		idx = idx.first();
		repeat (4) begin
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_wdata <= vals[idx];
			@(negedge clk);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
		c_debounce = s.deb;
		c_hold = s.hold;
		c_slow = s.slow;
		c_fast = s.fast;
	endtask

	// A rest, then a press of short or long length with some bounce; now and then pure noise.
	task automatic gesture_burst();
		int hold_cap;
		int press_len;
		hold_cap = (c_hold > 200) ? 200 : int'(c_hold);
		if (hold_cap < 1)
			hold_cap = 1;
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 8)) send_tick(1'($urandom), 1'b0, IdleWord);
		end else begin
			press_len = $urandom_range(0, 1) ? $urandom_range(1, hold_cap)
				: $urandom_range(hold_cap, 2 * hold_cap + 2);
			repeat ($urandom_range(0, int'(c_debounce) + 4)) send_tick(1'b0, 1'b0, IdleWord);
			repeat (press_len) send_tick($urandom_range(0, 99) >= 5, 1'b0, IdleWord);
		end
	endtask

	initial begin
		reg_set_t sets[7];
		int       counts[7];
		int       set_no;
		int       target;
		in_valid = 1'b0;
		button_down = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bglb_pkg::R_DEBOUNCE;
		cfg_wdata = '0;
		arst_n = 1'b0;
		set_no = 0;
		counts = '{450, 250, 500, 100, 100, 100, 100};
		sets[0] = '{8'd2, 16'd6, 16'd3, 16'd1};
		sets[1] = '{8'd0, 16'd1, 16'd0, 16'd0};
		sets[2] = '{8'd255, 16'd40, 16'd5, 16'd2};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].load) begin
				settle();
				program_regs(dir_sets[set_no]);
				set_no++;
			end else begin
				send_tick(script[i].btn, script[i].typed, script[i].word);
			end
		end
		typed_on = 1'b0;

		for (int p = 0; p < 7; p++) begin
			if (p >= 3)
				sets[p] = '{8'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
					16'($urandom_range(0, 9)), 16'($urandom_range(0, 9))};
			settle();
			program_regs(sets[p]);
			// Second phase runs without gaps; the receiver stalls long enough to back up the input.
			calm = (p == 1);
			if (p == 1)
				squeeze_req = 1'b1;
			target = ticks_sent + counts[p];
			while (ticks_sent < target)
				gesture_burst();
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[button_gesture_led_blinker.f]
hw/rtl/bglb_pkg.sv
hw/rtl/button_gesture_led_blinker.sv
test/tb_button_gesture_led_blinker.sv
